// ----- rtl/core/cumulative_weight_sampler_assert.svh -----
// assertion macros used by the rtl files (included by cws_back)
`ifndef CUMULATIVE_WEIGHT_SAMPLER_ASSERT_SVH
`define CUMULATIVE_WEIGHT_SAMPLER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CWS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CWS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/core/cws_pkg.sv -----
`default_nettype none
package cws_pkg;

  localparam int CFG_W           = 7;
  localparam int ROW_W           = 6;
  localparam int COL_W           = 6;
  localparam int WEIGHT_W        = 32;
  localparam int SUM_W           = 48;
  localparam int IDX_W           = 6;
  localparam int IN_TDATA_W      = 96;
  localparam int OUT_TDATA_W     = 8;
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    column;
    logic [WEIGHT_W-1:0] weight;
    logic [SUM_W-1:0]    draw;
  } req_t;

endpackage
`default_nettype wire

// ----- rtl/core/cumulative_weight_sampler.sv -----
`default_nettype none
// Row-wise running-sum table with inverse-CDF sampling. A load request (tuser 0) stores
// the weight, or the left neighbor's sum plus the weight saturated to 48 bits; columns of
// a row must be loaded in order from zero. A query request (tuser 1) returns the sampled
// column by bisection over the row. Requests pass through a two-entry queue to a single
// engine owning a sum memory with registered read data that it never reads and writes at
// once, so cost follows from memory accesses: a load of column zero is one write, other
// loads read the left neighbor's sum and then write, and a query reads the row's first
// sum and, if needed, its second-to-last, then bisects and loads the result register,
// which moves to the output register when free; accepted requests wait in the queue until
// the engine is idle. Out-of-range requests are dropped at the input and take no engine
// time. The memory has no clearing pass; a row must be loaded before it is queried.
module cumulative_weight_sampler import cws_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_W-1:0]       cfg_wdata,      // entries_in_use
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,       // row, column, weight, draw, zero pad
  input  wire logic                   in_tuser,       // mode
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata       // chosen_index, zero pad
);

  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  req_t             push_req;
  req_t             head_req;
  logic [CFG_W-1:0] n_used;

  cws_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_req     (push_req),
    .n_used    (n_used)
  );

  cws_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_req (head_req)
  );

  cws_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .n_used     (n_used),
    .q_valid    (q_valid),
    .q_req      (head_req),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ----- rtl/core/cws_front.sv -----
`default_nettype none
module cws_front import cws_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic                  in_tuser,
  input  wire logic                  q_full,
  output logic                       q_push,
  output req_t                       q_req,
  output logic [CFG_W-1:0]           n_used
);

  localparam int          NMAX_I = (MAX_ENTRIES < 127) ? MAX_ENTRIES : 127;
  localparam logic [CFG_W-1:0] NMAX = CFG_W'(NMAX_I);
  localparam logic [CFG_W-1:0] NMIN = CFG_W'(2);

  logic [CFG_W-1:0] entries_r;
  logic             keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= CFG_W'(64);
    end else if (cfg_we) begin
      entries_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (entries_r < NMIN) begin
      n_used = NMIN;
    end else if (entries_r > NMAX) begin
      n_used = NMAX;
    end else begin
      n_used = entries_r;
    end
  end

  assign q_req.mode   = in_tuser;
  assign q_req.row    = in_tdata[5:0];
  assign q_req.column = in_tdata[11:6];
  assign q_req.weight = in_tdata[43:12];
  assign q_req.draw   = in_tdata[91:44];

  // out-of-range rows and columns are dropped here
  always_comb begin
    if (q_req.mode == MODE_LOAD) begin
      keep = ({1'b0, q_req.row} < n_used) && ({1'b0, q_req.column} < n_used);
    end else begin
      keep = ({1'b0, q_req.row} < n_used);
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready && keep;

endmodule
`default_nettype wire

// ----- rtl/core/cws_queue.sv -----
`default_nettype none
module cws_queue import cws_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  req_t      push_req,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output req_t      head_req
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  req_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_pop;

  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign head_req = slot_r[rd_ptr_r];
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/cws_back.sv -----
`default_nettype none
`include "cumulative_weight_sampler_assert.svh"
module cws_back import cws_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [CFG_W-1:0]       n_used,
  input  wire logic                   q_valid,
  input  req_t                        q_req,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int DEPTH = MAX_ENTRIES * MAX_ENTRIES;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_Q0, S_Q1, S_BIS, S_DONE} state_t;

  state_t           state_r, state_nxt;
  req_t             req_r, req_nxt;
  logic [CFG_W-1:0] lo_r, lo_nxt;
  logic [CFG_W-1:0] hi_r, hi_nxt;
  logic [CFG_W-1:0] mid_r, mid_nxt;
  logic [CFG_W-1:0] res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_index_r, out_index_nxt;

  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] rd_data_r;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_wa, mem_ra;
  logic [SUM_W-1:0] mem_wd;

  function automatic logic [AW-1:0] addr_of(input logic [ROW_W-1:0] r,
                                            input logic [CFG_W-1:0] c);
    logic [31:0] a;
    a = 32'(r) * 32'(MAX_ENTRIES) + 32'(c);
    return a[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  always_comb begin
    logic [SUM_W:0]   acc;
    logic [CFG_W-1:0] lo_t;
    logic [CFG_W-1:0] hi_t;
    logic [CFG_W:0]   msum;
    state_nxt     = state_r;
    req_nxt       = req_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_index_nxt = out_index_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_wa        = '0;
    mem_ra        = '0;
    mem_wd        = '0;
    acc           = {1'b0, rd_data_r} + (SUM_W + 1)'(req_r.weight);
    lo_t          = lo_r;
    hi_t          = hi_r;
    msum          = '0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          req_nxt = q_req;
          if (q_req.mode == MODE_LOAD) begin
            if (q_req.column == '0) begin
              mem_we = 1'b1;
              mem_wa = addr_of(q_req.row, '0);
              mem_wd = SUM_W'(q_req.weight);
            end else begin
              mem_re    = 1'b1;
              mem_ra    = addr_of(q_req.row, CFG_W'(q_req.column) - 1'b1);
              state_nxt = S_LOAD;
            end
          end else begin
            mem_re    = 1'b1;
            mem_ra    = addr_of(q_req.row, '0);
            state_nxt = S_Q0;
          end
        end
      end
      S_LOAD: begin
        // saturate at the top of the sum range
        mem_we    = 1'b1;
        mem_wa    = addr_of(req_r.row, CFG_W'(req_r.column));
        mem_wd    = acc[SUM_W] ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
        state_nxt = S_IDLE;
      end
      S_Q0: begin
        if (req_r.draw < rd_data_r) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = addr_of(req_r.row, n_used - CFG_W'(2));
          state_nxt = S_Q1;
        end
      end
      S_Q1: begin
        if (rd_data_r < req_r.draw) begin
          res_nxt   = n_used - 1'b1;
          state_nxt = S_DONE;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = n_used - 1'b1;
          mid_nxt   = (n_used - 1'b1) >> 1;
          mem_re    = 1'b1;
          mem_ra    = addr_of(req_r.row, (n_used - 1'b1) >> 1);
          state_nxt = S_BIS;
        end
      end
      S_BIS: begin
        if (rd_data_r > req_r.draw) begin
          lo_t = lo_r;
          hi_t = mid_r;
        end else begin
          lo_t = mid_r + 1'b1;
          hi_t = hi_r;
        end
        msum   = {1'b0, lo_t} + {1'b0, hi_t};
        lo_nxt = lo_t;
        hi_nxt = hi_t;
        if (lo_t < hi_t) begin
          mid_nxt = msum[CFG_W:1];
          mem_re  = 1'b1;
          mem_ra  = addr_of(req_r.row, msum[CFG_W:1]);
        end else begin
          res_nxt   = lo_t;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = res_r[IDX_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r       <= req_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    res_r       <= res_nxt;
    out_index_r <= out_index_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_index_r);

  `CWS_ASSERT(a_no_rw_clash, clk, rst_n, mem_we |-> !mem_re, "memory read and write clash")
  `CWS_ASSERT(a_bis_range, clk, rst_n, (state_r == S_BIS) |-> (lo_r < hi_r), "empty search range")
  `CWS_ASSERT(a_res_range, clk, rst_n, (state_r == S_DONE) |-> (res_r < n_used), "index too large")
  `CWS_ASSERT_NEXT(a_result_out, clk, rst_n, (state_r == S_DONE) && (!out_valid_r || out_tready), out_valid_r && (state_r == S_IDLE), "result lost")

endmodule
`default_nettype wire
